>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every edge outside reset
`define DSNR_ASSERT_NOW(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// check a consequence in the cycle after its cause
`define DSNR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> sv/dsnr_pkg.sv
package dsnr_pkg;

	localparam int MUL_LAT = 4;
	localparam int ADD_LAT = 5;

	localparam logic [31:0] SEED_MAGIC   = 32'hbfcd_d90a;
	localparam logic [63:0] ONE_HALF     = 64'h3fe0_0000_0000_0000;
	localparam logic [63:0] THREE_HALVES = 64'h3ff8_0000_0000_0000;
	localparam logic [63:0] DEFAULT_NAN  = 64'hfff8_0000_0000_0000;
	localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;

	function automatic logic [5:0] lzc56(input logic [55:0] v);
		logic [5:0] n;
		n = 6'd56;
		for (int i = 0; i < 56; i++) begin
			if (v[i]) begin
				n = 6'(55 - i);
			end
		end
		return n;
	endfunction

endpackage

>>> sv/dsnr_if.sv
interface dsnr_operand_if;
	logic        valid;
	logic        ready;
	logic [63:0] operand_bits;

	modport source (output valid, output operand_bits, input ready);
	modport sink (input valid, input operand_bits, output ready);
endinterface

interface dsnr_root_if;
	logic        valid;
	logic        ready;
	logic [63:0] root_bits;

	modport source (output valid, output root_bits, input ready);
	modport sink (input valid, input root_bits, output ready);
endinterface

>>> sv/dsnr_fmul.sv
module dsnr_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        res_vld,
	output logic [63:0] res
);
	import dsnr_pkg::*;

	logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [10:0] ea, eb;
	logic [51:0] fa, fb;
	logic        spec_c;
	logic [63:0] specv_c;
	logic [52:0] ma_c, mb_c;

	logic        v_s1, spec_s1, sgn_s1;
	logic [63:0] specv_s1;
	logic [52:0] ma_s1, mb_s1;
	logic [10:0] eza_s1, ezb_s1;
	logic [5:0]  lza_s1, lzb_s1;

	logic [52:0] na, nb;
	logic signed [12:0] e_c;

	logic        v_s2, spec_s2, sgn_s2;
	logic [63:0] specv_s2;
	logic signed [12:0] e_s2;
	logic [51:0] hh_s2;
	logic [52:0] hl_s2, lh_s2;
	logic [53:0] ll_s2;

	logic        v_s3, spec_s3, sgn_s3;
	logic [63:0] specv_s3;
	logic signed [12:0] e_s3;
	logic [105:0] p_s3;

	logic signed [12:0] e1, shs;
	logic [105:0] q, sq;
	logic [6:0]   sh7;
	logic         ovf, den, lost, g, st, inc;
	logic [10:0]  efield;
	logic [62:0]  packed_c, rnd;
	logic [63:0]  res_c;

	logic        v_s4;
	logic [63:0] res_s4;

	always_comb begin
		sa = a[63];
		sb = b[63];
		ea = a[62:52];
		eb = b[62:52];
		fa = a[51:0];
		fb = b[51:0];
		a_nan  = (ea == 11'h7ff) && (fa != 52'd0);
		b_nan  = (eb == 11'h7ff) && (fb != 52'd0);
		a_inf  = (ea == 11'h7ff) && (fa == 52'd0);
		b_inf  = (eb == 11'h7ff) && (fb == 52'd0);
		a_zero = (ea == 11'd0) && (fa == 52'd0);
		b_zero = (eb == 11'd0) && (fb == 52'd0);
		spec_c  = 1'b1;
		specv_c = 64'd0;
		priority if (a_nan) begin
			specv_c = a | QUIET_BIT;
		end else if (b_nan) begin
			specv_c = b | QUIET_BIT;
		end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
			specv_c = DEFAULT_NAN;
		end else if (a_inf || b_inf) begin
			specv_c = {sa ^ sb, 11'h7ff, 52'd0};
		end else if (a_zero || b_zero) begin
			specv_c = {sa ^ sb, 63'd0};
		end else begin
			spec_c = 1'b0;
		end
		ma_c = {ea != 11'd0, fa};
		mb_c = {eb != 11'd0, fb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1  <= spec_c;
			specv_s1 <= specv_c;
			sgn_s1   <= sa ^ sb;
			ma_s1    <= ma_c;
			mb_s1    <= mb_c;
			eza_s1   <= (ea == 11'd0) ? 11'd1 : ea;
			ezb_s1   <= (eb == 11'd0) ? 11'd1 : eb;
			lza_s1   <= lzc56({ma_c, 3'b000});
			lzb_s1   <= lzc56({mb_c, 3'b000});
		end
	end

	always_comb begin
		na  = ma_s1 << lza_s1;
		nb  = mb_s1 << lzb_s1;
		e_c = $signed({2'b00, eza_s1}) + $signed({2'b00, ezb_s1})
			- $signed({7'd0, lza_s1}) - $signed({7'd0, lzb_s1}) - 13'sd1023;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s2  <= spec_s1;
			specv_s2 <= specv_s1;
			sgn_s2   <= sgn_s1;
			e_s2     <= e_c;
			hh_s2    <= na[52:27] * nb[52:27];
			hl_s2    <= na[52:27] * nb[26:0];
			lh_s2    <= na[26:0] * nb[52:27];
			ll_s2    <= na[26:0] * nb[26:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s3  <= spec_s2;
			specv_s3 <= specv_s2;
			sgn_s3   <= sgn_s2;
			e_s3     <= e_s2;
			p_s3     <= (106'(hh_s2) << 54) + ((106'(hl_s2) + 106'(lh_s2)) << 27)
				+ 106'(ll_s2);
		end
	end

	always_comb begin
		e1   = e_s3 + $signed({12'd0, p_s3[105]});
		q    = p_s3[105] ? p_s3 : (p_s3 << 1);
		ovf  = e1 >= 13'sd2047;
		den  = e1 <= 13'sd0;
		shs  = 13'sd1 - e1;
		if (!den) begin
			sh7 = 7'd0;
		end else if (shs > 13'sd107) begin
			sh7 = 7'd107;
		end else begin
			sh7 = shs[6:0];
		end
		sq     = q >> sh7;
		lost   = |(q & ~({106{1'b1}} << sh7));
		efield = den ? 11'd0 : e1[10:0];
		packed_c = {efield, sq[104:53]};
		g      = sq[52];
		st     = (|sq[51:0]) | lost;
		inc    = g & (st | sq[53]);
		rnd    = packed_c + 63'(inc);
		if (spec_s3) begin
			res_c = specv_s3;
		end else if (ovf) begin
			res_c = {sgn_s3, 11'h7ff, 52'd0};
		end else begin
			res_c = {sgn_s3, rnd};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= res_c;
		end
	end

	assign res_vld = v_s4;
	assign res     = res_s4;

endmodule

>>> sv/dsnr_fsub.sv
module dsnr_fsub (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        res_vld,
	output logic [63:0] res
);
	import dsnr_pkg::*;

	logic        sa, sbe, a_nan, b_nan, a_inf, b_inf, swap;
	logic [10:0] ea, eb, el, es, elz, esz;
	logic [51:0] fa, fb, fl, fs;
	logic        spec_c;
	logic [63:0] specv_c;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        spec_s1, spec_s2, spec_s3, spec_s4;
	logic [63:0] specv_s1, specv_s2, specv_s3, specv_s4;
	logic        sl_s1, ss_s1, sl_s2, ss_s2, sl_s3, ss_s3, sl_s4, ss_s4;
	logic [10:0] el_s1, el_s2, el_s3, el_s4, diff_s1;
	logic [52:0] ml_s1, ms_s1;

	logic [6:0]  d7;
	logic [55:0] mse, shd, als_c;
	logic        lost;
	logic [55:0] ml_s2, als_s2;

	logic [56:0] sum_s3, sum_s4;
	logic [5:0]  lz_s4;
	logic        zero_s4;

	logic [11:0] efc;
	logic        ovf, g, st, lsb, inc;
	logic [5:0]  sh;
	logic [55:0] t;
	logic [10:0] efield;
	logic [51:0] frac;
	logic [62:0] rnd;
	logic [63:0] res_c, res_s5;

	always_comb begin
		sa  = a[63];
		sbe = ~b[63];
		ea  = a[62:52];
		eb  = b[62:52];
		fa  = a[51:0];
		fb  = b[51:0];
		a_nan = (ea == 11'h7ff) && (fa != 52'd0);
		b_nan = (eb == 11'h7ff) && (fb != 52'd0);
		a_inf = (ea == 11'h7ff) && (fa == 52'd0);
		b_inf = (eb == 11'h7ff) && (fb == 52'd0);
		spec_c  = 1'b1;
		specv_c = 64'd0;
		priority if (a_nan) begin
			specv_c = a | QUIET_BIT;
		end else if (b_nan) begin
			specv_c = b | QUIET_BIT;
		end else if (a_inf && b_inf && (sa != sbe)) begin
			specv_c = DEFAULT_NAN;
		end else if (a_inf) begin
			specv_c = a;
		end else if (b_inf) begin
			specv_c = {sbe, 11'h7ff, 52'd0};
		end else begin
			spec_c = 1'b0;
		end
		swap = b[62:0] > a[62:0];
		el  = swap ? eb : ea;
		es  = swap ? ea : eb;
		fl  = swap ? fb : fa;
		fs  = swap ? fa : fb;
		elz = (el == 11'd0) ? 11'd1 : el;
		esz = (es == 11'd0) ? 11'd1 : es;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1  <= spec_c;
			specv_s1 <= specv_c;
			sl_s1    <= swap ? sbe : sa;
			ss_s1    <= swap ? sa : sbe;
			el_s1    <= elz;
			diff_s1  <= elz - esz;
			ml_s1    <= {el != 11'd0, fl};
			ms_s1    <= {es != 11'd0, fs};
		end
	end

	always_comb begin
		d7    = (diff_s1 > 11'd63) ? 7'd63 : {1'b0, diff_s1[5:0]};
		mse   = {ms_s1, 3'b000};
		shd   = mse >> d7;
		lost  = |(mse & ~({56{1'b1}} << d7));
		als_c = {shd[55:1], shd[0] | lost};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s2  <= spec_s1;
			specv_s2 <= specv_s1;
			sl_s2    <= sl_s1;
			ss_s2    <= ss_s1;
			el_s2    <= el_s1;
			ml_s2    <= {ml_s1, 3'b000};
			als_s2   <= als_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s3  <= spec_s2;
			specv_s3 <= specv_s2;
			sl_s3    <= sl_s2;
			ss_s3    <= ss_s2;
			el_s3    <= el_s2;
			sum_s3   <= (sl_s2 != ss_s2) ? ({1'b0, ml_s2} - {1'b0, als_s2})
				: ({1'b0, ml_s2} + {1'b0, als_s2});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s4  <= spec_s3;
			specv_s4 <= specv_s3;
			sl_s4    <= sl_s3;
			ss_s4    <= ss_s3;
			el_s4    <= el_s3;
			sum_s4   <= sum_s3;
			lz_s4    <= lzc56(sum_s3[55:0]);
			zero_s4  <= sum_s3 == 57'd0;
		end
	end

	always_comb begin
		efc = {1'b0, el_s4} + 12'd1;
		ovf = sum_s4[56] && (efc >= 12'd2047);
		sh  = (11'(lz_s4) < el_s4) ? lz_s4 : 6'(el_s4 - 11'd1);
		t   = sum_s4[55:0] << sh;
		if (sum_s4[56]) begin
			efield = efc[10:0];
			frac   = sum_s4[55:4];
			g      = sum_s4[3];
			st     = |sum_s4[2:0];
			lsb    = sum_s4[4];
		end else begin
			efield = t[55] ? (el_s4 - 11'(sh)) : 11'd0;
			frac   = t[54:3];
			g      = t[2];
			st     = |t[1:0];
			lsb    = t[3];
		end
		inc = g & (st | lsb);
		rnd = {efield, frac} + 63'(inc);
		if (spec_s4) begin
			res_c = specv_s4;
		end else if (zero_s4) begin
			res_c = {sl_s4 & ss_s4, 63'd0};
		end else if (ovf) begin
			res_c = {sl_s4, 11'h7ff, 52'd0};
		end else begin
			res_c = {sl_s4, rnd};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5 <= res_c;
		end
	end

	assign res_vld = v_s5;
	assign res     = res_s5;

endmodule

>>> sv/double_sqrt_newton_rsqrt.sv
// Approximate square root of an IEEE-754 double, fast inverse-sqrt scheme.
// Channels: operand (sink, operand_bits) and root (source, root_bits), both
// valid/ready; a request moves on an edge where valid and ready are high.
// The seed comes from the operand's bits, NEWTON_STEPS Newton refinements
// follow in round-to-nearest-even double arithmetic, and the result is the
// refined reciprocal root times the operand.
// Throughput: one request per cycle while root is not stalled, with no
// bubbles between requests. Each step runs three multipliers side by side,
// one multiplier for the cube term and one subtractor; each multiplier
// splits the 53x53 product into four partial products over its stages.
// Reset clears all valid bits; payload registers are not reset.
// When root is stalled the whole pipeline holds and operand.ready drops, so
// no request is lost or repeated; while a result waits unaccepted in the
// output register, operand.ready stays low.
`include "assert_macros.svh"

module double_sqrt_newton_rsqrt #(
	parameter int NEWTON_STEPS = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	dsnr_operand_if.sink   operand,
	dsnr_root_if.source    root
);
	import dsnr_pkg::*;

	localparam int STEP_LAT = 2 * MUL_LAT + ADD_LAT;

	logic        pipe_en;
	logic [31:0] seed_hi;
	logic [63:0] sd_q [MUL_LAT];
	logic [63:0] yd_q [MUL_LAT];

	logic [63:0] x_st [NEWTON_STEPS + 1];
	logic [63:0] y_st [NEWTON_STEPS + 1];
	logic [63:0] h_st [NEWTON_STEPS];
	logic [NEWTON_STEPS:0] v_st;
	logic [2:0]  v_mul [NEWTON_STEPS];

	assign pipe_en       = !root.valid || root.ready;
	assign operand.ready = pipe_en;
	assign seed_hi       = (SEED_MAGIC - operand.operand_bits[63:32]) >> 1;

	dsnr_fmul u_half (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (pipe_en),
		.vld     (operand.valid),
		.a       (operand.operand_bits),
		.b       (ONE_HALF),
		.res_vld (v_st[0]),
		.res     (h_st[0])
	);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			sd_q[0] <= {seed_hi, operand.operand_bits[31:0]};
			yd_q[0] <= operand.operand_bits;
			for (int i = 1; i < MUL_LAT; i++) begin
				sd_q[i] <= sd_q[i-1];
				yd_q[i] <= yd_q[i-1];
			end
		end
	end

	assign x_st[0] = sd_q[MUL_LAT-1];
	assign y_st[0] = yd_q[MUL_LAT-1];

	for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
		logic [63:0] lin, sq, xh, cube;
		logic        cube_v;
		logic [63:0] ld_q [MUL_LAT];
		logic [63:0] hd_q [STEP_LAT];
		logic [63:0] ydl_q [STEP_LAT];

		dsnr_fmul u_lin (
			.clk (clk), .arst_n (arst_n), .en (pipe_en), .vld (v_st[k]),
			.a (THREE_HALVES), .b (x_st[k]), .res_vld (v_mul[k][0]), .res (lin)
		);
		dsnr_fmul u_sq (
			.clk (clk), .arst_n (arst_n), .en (pipe_en), .vld (v_st[k]),
			.a (x_st[k]), .b (x_st[k]), .res_vld (v_mul[k][1]), .res (sq)
		);
		dsnr_fmul u_xh (
			.clk (clk), .arst_n (arst_n), .en (pipe_en), .vld (v_st[k]),
			.a (x_st[k]), .b (h_st[k]), .res_vld (v_mul[k][2]), .res (xh)
		);
		dsnr_fmul u_cube (
			.clk (clk), .arst_n (arst_n), .en (pipe_en), .vld (v_mul[k][1]),
			.a (sq), .b (xh), .res_vld (cube_v), .res (cube)
		);
		dsnr_fsub u_sub (
			.clk (clk), .arst_n (arst_n), .en (pipe_en), .vld (cube_v),
			.a (ld_q[MUL_LAT-1]), .b (cube), .res_vld (v_st[k+1]), .res (x_st[k+1])
		);

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				ld_q[0]  <= lin;
				hd_q[0]  <= h_st[k];
				ydl_q[0] <= y_st[k];
				for (int i = 1; i < MUL_LAT; i++) begin
					ld_q[i] <= ld_q[i-1];
				end
				for (int i = 1; i < STEP_LAT; i++) begin
					hd_q[i]  <= hd_q[i-1];
					ydl_q[i] <= ydl_q[i-1];
				end
			end
		end

		assign y_st[k+1] = ydl_q[STEP_LAT-1];

		if (k + 1 < NEWTON_STEPS) begin : g_half
			assign h_st[k+1] = hd_q[STEP_LAT-1];
		end
	end

	dsnr_fmul u_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (pipe_en),
		.vld     (v_st[NEWTON_STEPS]),
		.a       (x_st[NEWTON_STEPS]),
		.b       (y_st[NEWTON_STEPS]),
		.res_vld (root.valid),
		.res     (root.root_bits)
	);

	for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_chk
		`DSNR_ASSERT_NOW(a_mul_lockstep, v_mul[k] == 3'b000 || v_mul[k] == 3'b111)
	end

	`DSNR_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable(v_st))

endmodule
